// ----- rtl/core/gst_pkg.sv -----
`default_nettype none
package gst_pkg;

	// Table geometry.
	localparam int SLOT_COUNT = 32;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);

	// Time constants in 1/1024 s units: the wave saturates at its field maximum
	// and an explosion expires once the wave passes 1.5 s.
	localparam int            WAVE_W     = 12;
	localparam logic [11:0]   WAVE_MAX   = 12'd4095;
	localparam logic [11:0]   WAVE_LIMIT = 12'd1536;

	// Operation codes.
	localparam logic [2:0] OP_REGISTER   = 3'd0;
	localparam logic [2:0] OP_REMOVE     = 3'd1;
	localparam logic [2:0] OP_REMOVE_ENT = 3'd2;
	localparam logic [2:0] OP_TICK       = 3'd3;
	localparam logic [2:0] OP_LOOKUP     = 3'd4;

	// Slot kinds.
	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_CHARACTER = 3'd1;
	localparam logic [2:0] KIND_VEHICLE   = 3'd2;
	localparam logic [2:0] KIND_PROJECT   = 3'd3;
	localparam logic [2:0] KIND_EXPLOSION = 3'd4;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  kind;
		logic [31:0] entity_id;
		logic [23:0] lifetime;
		logic [4:0]  handle_slot;
		logic [15:0] handle_generation;
		logic [15:0] tick_delta;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  result_slot;
		logic [15:0] result_generation;
		logic [2:0]  result_kind;
		logic [5:0]  changed_count;
		logic [5:0]  active_count;
	} out_word_t;

	// One slot record as held in the slot memory.
	typedef struct packed {
		logic [15:0]       generation;
		logic [2:0]        kind;
		logic [31:0]       entity;
		logic [23:0]       lifetime;
		logic [WAVE_W-1:0] wave;
	} slot_rec_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_APPLY,
		S_SWEEP
	} ctl_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic issue;
		logic apply;
		logic sweep;
		logic finish;
	} ctl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic sweep_op;
		logic last;
	} ctl_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/gst_ctrl.sv -----
`default_nettype none
module gst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire gst_pkg::ctl_sts_t sts,
	output gst_pkg::ctl_cmd_t      cmd,
	output logic                   busy
);
	import gst_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_ISSUE;
				end
			end
			S_ISSUE: begin
				cmd.issue = 1'b1;
				state_d   = sts.sweep_op ? S_SWEEP : S_APPLY;
			end
			S_APPLY: begin
				cmd.apply  = 1'b1;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/gst_datapath.sv -----
`default_nettype none
module gst_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gst_pkg::ctl_cmd_t cmd,
	input  wire gst_pkg::in_word_t item,
	output gst_pkg::ctl_sts_t      sts,
	output logic                   done,
	output gst_pkg::out_word_t     result
);
	import gst_pkg::*;

	slot_rec_t slot_mem [SLOT_COUNT];
	slot_rec_t rd_q;

	logic [SLOT_COUNT-1:0] active_q;
	logic [SLOT_COUNT-1:0] gen_valid_q;
	logic [5:0]            live_q;
	logic [5:0]            chg_q;
	logic                  done_q;
	in_word_t              item_q;
	logic [SLOT_W-1:0]     cur_q;
	out_word_t             res_q;

	logic [SLOT_W-1:0] free_idx;
	logic              full;
	logic [SLOT_W-1:0] rd_addr;
	logic              rd_en;
	logic              wr_en;
	slot_rec_t         wr_rec;

	logic              cur_act;
	logic [15:0]       cur_gen;
	logic [15:0]       new_gen;
	logic              kind_ok;
	logic              handle_ok;
	logic              set_act;
	logic              clr_act;
	logic [5:0]        live_dec;
	logic [5:0]        live_d;
	out_word_t         res_d;

	logic              life_exp;
	logic [23:0]       life_new;
	logic              is_expl;
	logic [17:0]       wave_sum;
	logic [WAVE_W-1:0] wave_new;
	logic              wave_exp;
	logic              retire;

	assign sts.sweep_op = (item_q.op == OP_REMOVE_ENT) || (item_q.op == OP_TICK);
	assign sts.last     = (cur_q == SLOT_W'(SLOT_COUNT - 1));

	// Lowest free slot.
	always_comb begin
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
	end
	assign full = &active_q;

	always_comb begin
		if (cmd.sweep) begin
			rd_addr = cur_q + 1'b1;
		end else if (sts.sweep_op) begin
			rd_addr = '0;
		end else if (item_q.op == OP_REGISTER) begin
			rd_addr = free_idx;
		end else begin
			rd_addr = item_q.handle_slot;
		end
	end
	assign rd_en = cmd.issue | cmd.sweep;

	// Decode of the slot under work.
	assign cur_act   = active_q[cur_q];
	assign cur_gen   = gen_valid_q[cur_q] ? rd_q.generation : 16'd0;
	assign new_gen   = ((cur_gen + 16'd1) == 16'd0) ? 16'd1 : cur_gen + 16'd1;
	assign kind_ok   = (item_q.kind >= KIND_CHARACTER) && (item_q.kind <= KIND_EXPLOSION);
	assign handle_ok = (item_q.handle_generation != 16'd0) && cur_act &&
		(cur_gen == item_q.handle_generation);
	assign live_dec  = (live_q != 6'd0) ? live_q - 6'd1 : 6'd0;

	// Tick update of one slot: lifetime first, then the explosion wave.
	always_comb begin
		life_exp = cur_act && (rd_q.lifetime != 24'd0) &&
			(rd_q.lifetime <= {8'd0, item_q.tick_delta});
		if (life_exp) begin
			life_new = 24'd0;
		end else if (cur_act && (rd_q.lifetime != 24'd0)) begin
			life_new = rd_q.lifetime - {8'd0, item_q.tick_delta};
		end else begin
			life_new = rd_q.lifetime;
		end
		is_expl  = cur_act && !life_exp && (rd_q.kind == KIND_EXPLOSION);
		wave_sum = {6'd0, rd_q.wave} + {1'b0, item_q.tick_delta, 1'b0};
		wave_new = (wave_sum > {6'd0, WAVE_MAX}) ? WAVE_MAX : wave_sum[WAVE_W-1:0];
		wave_exp = is_expl && (wave_new > WAVE_LIMIT);
	end

	always_comb begin
		retire  = 1'b0;
		wr_en   = 1'b0;
		wr_rec  = rd_q;
		set_act = 1'b0;
		clr_act = 1'b0;
		live_d  = live_q;
		res_d   = '0;
		if (cmd.apply) begin
			case (item_q.op)
				OP_REGISTER: begin
					if (!kind_ok) begin
						res_d.status = STAT_BAD;
					end else if (full) begin
						res_d.status = STAT_FULL;
					end else begin
						set_act              = 1'b1;
						wr_en                = 1'b1;
						wr_rec.generation    = new_gen;
						wr_rec.kind          = item_q.kind;
						wr_rec.entity        = (item_q.kind >= KIND_PROJECT) ? 32'd0 :
							item_q.entity_id;
						wr_rec.lifetime      = ((item_q.kind == KIND_CHARACTER) ||
							(item_q.kind == KIND_EXPLOSION)) ? item_q.lifetime : 24'd0;
						wr_rec.wave          = '0;
						live_d               = live_q + 6'd1;
						res_d.result_slot       = cur_q;
						res_d.result_generation = new_gen;
						res_d.result_kind       = item_q.kind;
					end
				end
				OP_REMOVE: begin
					if (handle_ok) begin
						clr_act                 = 1'b1;
						live_d                  = live_dec;
						res_d.result_slot       = cur_q;
						res_d.result_generation = item_q.handle_generation;
					end else begin
						res_d.status = STAT_BAD;
					end
				end
				OP_LOOKUP: begin
					if (handle_ok) begin
						res_d.result_slot       = cur_q;
						res_d.result_generation = item_q.handle_generation;
						res_d.result_kind       = rd_q.kind;
					end else begin
						res_d.status = STAT_BAD;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.sweep) begin
			if (item_q.op == OP_TICK) begin
				retire          = life_exp || wave_exp;
				wr_en           = cur_act;
				wr_rec.lifetime = life_new;
				wr_rec.wave     = is_expl ? wave_new : rd_q.wave;
				wr_rec.kind     = retire ? KIND_NONE : rd_q.kind;
			end else begin
				retire = cur_act && (rd_q.entity == item_q.entity_id);
			end
			clr_act = retire;
			if (retire) begin
				live_d = live_dec;
			end
			res_d.changed_count = chg_q + {5'd0, retire};
		end
		res_d.active_count = live_d;
	end

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[cur_q] <= wr_rec;
		end
		if (rd_en) begin
			rd_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			gen_valid_q <= '0;
			live_q      <= '0;
			chg_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			live_q <= live_d;
			if (set_act) begin
				active_q[cur_q]    <= 1'b1;
				gen_valid_q[cur_q] <= 1'b1;
			end else if (clr_act) begin
				active_q[cur_q] <= 1'b0;
			end
			if (cmd.load) begin
				chg_q <= '0;
			end else if (cmd.sweep) begin
				chg_q <= res_d.changed_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		if (cmd.issue) begin
			cur_q <= rd_addr;
		end else if (cmd.sweep) begin
			cur_q <= cur_q + 1'b1;
		end
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_live_matches: assert property (@(posedge clk) disable iff (!arst_n)
		live_q == 6'($countones(active_q)))
		else $error("live count differs from number of active slots");

endmodule
`default_nettype wire

// ----- rtl/core/generational_slot_table_with_lifetimes_unit.sv -----
`default_nettype none
// The result word for register, remove, lookup and unknown ops is registered after the issue
// and apply states; for remove by entity and tick it follows the issue state and a sweep,
// which visits the 32 slots one per cycle through the single read port of the slot memory.
// The unit takes no new word until the result of the last one is shown.
// Reset (arst_n low, asynchronous) clears active flags, generations and the live count.
// Results are strobed by done for one cycle; the receiver cannot stall them.
module generational_slot_table_with_lifetimes_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire gst_pkg::in_word_t item,
	output logic                   busy,
	output logic                   done,
	output gst_pkg::out_word_t     result
);
	import gst_pkg::*;

	// The controller sequences each word: an issue cycle reads the slot record
	// (the lowest free slot for register, the handle's slot for remove and
	// lookup, slot zero for a sweep), then either a single apply cycle or a
	// sweep that processes one slot per cycle while fetching the next.
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	gst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the slot memory, the active and generation-valid
	// flags, the live count and the result register.
	gst_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

	// A result is only shown while the unit is free to take a new word.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// An accepted word keeps the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not make the unit busy");

	// Reported counts and status stay within their meaning.
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.active_count <= 6'(SLOT_COUNT)) &&
			(result.changed_count <= 6'(SLOT_COUNT)) && (result.status != 2'd3)))
		else $error("result field out of range");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`default_nettype none
// Testbench for the generational slot table. Every command word that the
// block accepts is run through a shadow copy of the slot table kept here,
// which yields the answer word that the block must strobe out later. The
// checker compares each strobed answer with the oldest answer still due.
module tb_top;
	import gst_pkg::*;

	// Op codes 5 to 7 are not defined by the block and must be answered with an ok
	// word that reports only the active count. Kind 7 is one of the illegal register kinds.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [2:0] KIND_BAD_HI = 3'd7;

	// Random part: the first words fill the table so that the full answer
	// shows up early. The op mix then rotates every 200 words between a
	// balanced mix, a register-heavy mix and a teardown-heavy mix. Each
	// entry is a cumulative cutoff out of 100.
	localparam int RANDOM_ITEMS = 1400;
	localparam int FILL_ITEMS   = 40;
	localparam int CUT_REG[3]   = '{30, 50, 15};
	localparam int CUT_REM[3]   = '{50, 62, 45};
	localparam int CUT_ENT[3]   = '{58, 67, 60};
	localparam int CUT_TICK[3]  = '{73, 77, 85};
	localparam int CUT_LOOK[3]  = '{95, 97, 97};

	// A sweep and the longest pause of the sender are both shorter than
	// the watchdog limit, so reaching it means the block is stuck.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 40;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_word_t  item   = '0;
	logic      busy;
	logic      done;
	out_word_t result;

	generational_slot_table_with_lifetimes_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow copy of the slot table. Owner, lifetime and wave are only read
	// for live slots, and a register always writes them first.
	logic        shadow_active [SLOT_COUNT];
	logic [15:0] shadow_gen    [SLOT_COUNT];
	logic [2:0]  shadow_kind   [SLOT_COUNT];
	logic [31:0] shadow_owner  [SLOT_COUNT];
	logic [23:0] shadow_life   [SLOT_COUNT];
	logic [11:0] shadow_wave   [SLOT_COUNT];
	int          shadow_live;

	out_word_t due_answers [$];
	int        mismatches = 0;
	int        stall_cycles = 0;

	// One row of the directed part. When typed is set, want is the answer
	// written out by hand; otherwise the shadow table supplies the answer.
	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} stim_row_t;

	stim_row_t dir_rows [$];

	function automatic in_word_t word_of(input logic [2:0] op, input logic [2:0] kind,
			input logic [31:0] owner, input logic [23:0] life, input logic [4:0] hs,
			input logic [15:0] hg, input logic [15:0] delta);
		in_word_t w;
		w.op                = op;
		w.kind              = kind;
		w.entity_id         = owner;
		w.lifetime          = life;
		w.handle_slot       = hs;
		w.handle_generation = hg;
		w.tick_delta        = delta;
		return w;
	endfunction

	function automatic out_word_t answer_of(input logic [1:0] status, input logic [4:0] slot,
			input logic [15:0] gen, input logic [2:0] kind, input logic [5:0] changed,
			input logic [5:0] active);
		out_word_t a;
		a.status            = status;
		a.result_slot       = slot;
		a.result_generation = gen;
		a.result_kind       = kind;
		a.changed_count     = changed;
		a.active_count      = active;
		return a;
	endfunction

	task automatic add_row(input in_word_t w, input bit typed, input out_word_t want);
		stim_row_t row;
		row.w     = w;
		row.typed = typed;
		row.want  = want;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// Freeing a slot clears its kind and lowers the live count, never below zero.
	function automatic void retire_slot(input int s);
		shadow_active[s] = 1'b0;
		shadow_kind[s]   = KIND_NONE;
		if (shadow_live > 0)
			shadow_live--;
	endfunction

	function automatic bit handle_live(input logic [4:0] hs, input logic [15:0] hg);
		return hg != 16'd0 && shadow_active[hs] && shadow_gen[hs] == hg;
	endfunction

	// Applies one accepted command word to the shadow table and returns the
	// answer word the block has to produce for it.
	function automatic out_word_t apply_slot_op(input in_word_t w);
		out_word_t   a;
		int          i;
		int          s;
		int          changed;
		logic [15:0] g;
		logic [31:0] wave;
		a       = '0;
		changed = 0;
		case (w.op)
			OP_REGISTER: begin
				if (w.kind == KIND_NONE || w.kind > KIND_EXPLOSION) begin
					a.status = STAT_BAD;
				end else begin
					// The lowest free slot wins.
					s = -1;
					for (i = SLOT_COUNT - 1; i >= 0; i--)
						if (!shadow_active[i])
							s = i;
					if (s < 0) begin
						a.status = STAT_FULL;
					end else begin
						// Generation zero marks the invalid handle, so it is skipped on wrap.
						g = shadow_gen[s] + 16'd1;
						if (g == 16'd0)
							g = 16'd1;
						shadow_gen[s]    = g;
						shadow_active[s] = 1'b1;
						shadow_kind[s]   = w.kind;
						// Projectiles and explosions have no owner; vehicles and
						// projectiles never time out.
						shadow_owner[s]  = (w.kind >= KIND_PROJECT) ? 32'd0 : w.entity_id;
						shadow_life[s]   = (w.kind == KIND_CHARACTER || w.kind == KIND_EXPLOSION)
							? w.lifetime : 24'd0;
						shadow_wave[s]   = '0;
						shadow_live++;
						a.result_slot       = s[4:0];
						a.result_generation = g;
						a.result_kind       = w.kind;
					end
				end
			end
			OP_REMOVE: begin
				if (handle_live(w.handle_slot, w.handle_generation)) begin
					retire_slot(w.handle_slot);
					a.result_slot       = w.handle_slot;
					a.result_generation = w.handle_generation;
				end else begin
					a.status = STAT_BAD;
				end
			end
			OP_REMOVE_ENT: begin
				for (i = 0; i < SLOT_COUNT; i++)
					if (shadow_active[i] && shadow_owner[i] == w.entity_id) begin
						retire_slot(i);
						changed++;
					end
			end
			OP_TICK: begin
				// Lifetimes count down first, over the whole table.
				for (i = 0; i < SLOT_COUNT; i++)
					if (shadow_active[i] && shadow_life[i] != 24'd0) begin
						if (shadow_life[i] <= w.tick_delta) begin
							shadow_life[i] = '0;
							retire_slot(i);
							changed++;
						end else begin
							shadow_life[i] = shadow_life[i] - w.tick_delta;
						end
					end
				// Then the surviving explosions push their wave out by twice the delta.
				for (i = 0; i < SLOT_COUNT; i++)
					if (shadow_active[i] && shadow_kind[i] == KIND_EXPLOSION) begin
						wave = 32'(shadow_wave[i]) + 32'(w.tick_delta) * 2;
						if (wave > WAVE_MAX)
							wave = 32'(WAVE_MAX);
						shadow_wave[i] = wave[11:0];
						if (wave > WAVE_LIMIT) begin
							retire_slot(i);
							changed++;
						end
					end
			end
			OP_LOOKUP: begin
				if (handle_live(w.handle_slot, w.handle_generation)) begin
					a.result_slot       = w.handle_slot;
					a.result_generation = w.handle_generation;
					a.result_kind       = shadow_kind[w.handle_slot];
				end else begin
					a.status = STAT_BAD;
				end
			end
			default: begin
			end
		endcase
		a.changed_count = changed[5:0];
		a.active_count  = shadow_live[5:0];
		return a;
	endfunction

	// Presents one command word and holds it until the block takes it. Start
	// is left high afterwards so that a following word can go out back to back.
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
		out_word_t predicted;
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		predicted = apply_slot_op(w);
		due_answers.insert(due_answers.size(), typed ? want : predicted);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_for_answers();
		start <= 1'b0;
		while (due_answers.size() != 0)
			@(posedge clk);
	endtask

	// Owners come mostly from a small pool so that remove by entity finds matches.
	function automatic logic [31:0] pick_owner();
		int r;
		r = $urandom_range(0, 5);
		if (r < 4)
			return r;
		if (r == 4)
			return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	// Results cannot be held off, so each strobed answer is taken at the
	// edge that ends its cycle and checked against the oldest one due.
	always @(posedge clk) begin : check_answers
		out_word_t want;
		if (arst_n && done) begin
			if (due_answers.size() == 0) begin
				$error("answer word with nothing due: %h", result);
				mismatches++;
			end else begin
				want = due_answers.pop_front();
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatches++;
				end
				if (result.result_slot !== want.result_slot) begin
					$error("result_slot: expected %0d, got %0d",
						want.result_slot, result.result_slot);
					mismatches++;
				end
				if (result.result_generation !== want.result_generation) begin
					$error("result_generation: expected %0d, got %0d",
						want.result_generation, result.result_generation);
					mismatches++;
				end
				if (result.result_kind !== want.result_kind) begin
					$error("result_kind: expected %0d, got %0d",
						want.result_kind, result.result_kind);
					mismatches++;
				end
				if (result.changed_count !== want.changed_count) begin
					$error("changed_count: expected %0d, got %0d",
						want.changed_count, result.changed_count);
					mismatches++;
				end
				if (result.active_count !== want.active_count) begin
					$error("active_count: expected %0d, got %0d",
						want.active_count, result.active_count);
					mismatches++;
				end
			end
		end
	end

	// The watchdog restarts whenever a word goes in or an answer comes out.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		in_word_t w;
		int       n;
		int       mix;
		int       r;
		int       tries;
		int       i;

		for (i = 0; i < SLOT_COUNT; i++) begin
			shadow_active[i] = 1'b0;
			shadow_gen[i]    = '0;
			shadow_kind[i]   = KIND_NONE;
			shadow_owner[i]  = '0;
			shadow_life[i]   = '0;
			shadow_wave[i]   = '0;
		end
		shadow_live = 0;

		// Directed part. On an empty table every handle is bad and sweeps do nothing.
		add_row(word_of(OP_LOOKUP, KIND_CHARACTER, 0, 0, 0, 16'd1, 0), 1,
			answer_of(STAT_BAD, 0, 0, KIND_NONE, 0, 0));
		add_row(word_of(OP_REMOVE, KIND_CHARACTER, 0, 0, 5'd31, 16'd0, 0), 1,
			answer_of(STAT_BAD, 0, 0, KIND_NONE, 0, 0));
		add_row(word_of(OP_TICK, KIND_NONE, 0, 0, 0, 0, 16'hFFFF), 1,
			answer_of(STAT_OK, 0, 0, KIND_NONE, 0, 0));
		add_row(word_of(OP_REMOVE_ENT, KIND_NONE, 0, 0, 0, 0, 0), 1,
			answer_of(STAT_OK, 0, 0, KIND_NONE, 0, 0));
		// Illegal register kinds at both ends leave the table alone.
		add_row(word_of(OP_REGISTER, KIND_NONE, 32'd1, 24'd1, 0, 0, 0), 1,
			answer_of(STAT_BAD, 0, 0, KIND_NONE, 0, 0));
		add_row(word_of(OP_REGISTER, KIND_BAD_HI, 32'd1, 24'd1, 0, 0, 0), 1,
			answer_of(STAT_BAD, 0, 0, KIND_NONE, 0, 0));
		// One register of each kind, with extreme owner and lifetime values.
		add_row(word_of(OP_REGISTER, KIND_CHARACTER, 32'hFFFF_FFFF, 24'hFF_FFFF, 0, 0, 0), 1,
			answer_of(STAT_OK, 5'd0, 16'd1, KIND_CHARACTER, 0, 6'd1));
		add_row(word_of(OP_REGISTER, KIND_VEHICLE, 32'd0, 24'd5, 0, 0, 0), 1,
			answer_of(STAT_OK, 5'd1, 16'd1, KIND_VEHICLE, 0, 6'd2));
		add_row(word_of(OP_REGISTER, KIND_PROJECT, 32'h1234_5678, 24'd100, 0, 0, 0), 1,
			answer_of(STAT_OK, 5'd2, 16'd1, KIND_PROJECT, 0, 6'd3));
		add_row(word_of(OP_REGISTER, KIND_EXPLOSION, 32'd9, 24'd0, 0, 0, 0), 1,
			answer_of(STAT_OK, 5'd3, 16'd1, KIND_EXPLOSION, 0, 6'd4));
		add_row(word_of(OP_LOOKUP, KIND_NONE, 0, 0, 5'd3, 16'd1, 0), 1,
			answer_of(STAT_OK, 5'd3, 16'd1, KIND_EXPLOSION, 0, 6'd4));
		// A stale generation is refused.
		add_row(word_of(OP_LOOKUP, KIND_NONE, 0, 0, 5'd3, 16'd2, 0), 1,
			answer_of(STAT_BAD, 0, 0, KIND_NONE, 0, 6'd4));
		add_row(word_of(OP_SPARE_LO, KIND_EXPLOSION, 32'hFFFF_FFFF, 24'hFF_FFFF, 5'd31,
			16'hFFFF, 16'hFFFF), 1, answer_of(STAT_OK, 0, 0, KIND_NONE, 0, 6'd4));
		add_row(word_of(OP_SPARE_HI, KIND_CHARACTER, 0, 0, 0, 16'd1, 16'd1), 1,
			answer_of(STAT_OK, 0, 0, KIND_NONE, 0, 6'd4));
		// The wave lands exactly on the 1.5 s limit, then one more unit expires it.
		add_row(word_of(OP_TICK, KIND_NONE, 0, 0, 0, 0, 16'd768), 0, '0);
		add_row(word_of(OP_TICK, KIND_NONE, 0, 0, 0, 0, 16'd1), 0, '0);
		// Owner zero takes the vehicle and the projectile, whose owner was forced to zero.
		add_row(word_of(OP_REMOVE_ENT, KIND_NONE, 32'd0, 0, 0, 0, 0), 0, '0);
		add_row(word_of(OP_REMOVE, KIND_NONE, 0, 0, 5'd0, 16'd1, 0), 1,
			answer_of(STAT_OK, 5'd0, 16'd1, KIND_NONE, 0, 6'd0));
		add_row(word_of(OP_REMOVE, KIND_NONE, 0, 0, 5'd0, 16'd1, 0), 1,
			answer_of(STAT_BAD, 0, 0, KIND_NONE, 0, 6'd0));
		// A short lifetime runs out on the largest tick.
		add_row(word_of(OP_REGISTER, KIND_CHARACTER, 32'd3, 24'd10, 0, 0, 0), 0, '0);
		add_row(word_of(OP_TICK, KIND_NONE, 0, 0, 0, 0, 16'hFFFF), 0, '0);
		add_row(word_of(OP_LOOKUP, KIND_NONE, 0, 0, 5'd31, 16'hFFFF, 0), 1,
			answer_of(STAT_BAD, 0, 0, KIND_NONE, 0, 6'd0));
		// An explosion with a long lifetime is ended by its wave instead.
		add_row(word_of(OP_REGISTER, KIND_EXPLOSION, 32'd7, 24'hFF_FFFF, 0, 0, 0), 0, '0);
		add_row(word_of(OP_TICK, KIND_NONE, 0, 0, 0, 0, 16'd1024), 0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			if ($urandom_range(0, 99) < 36)
				pause($urandom_range(1, 40));
			send_word(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);
		end
		wait_for_answers();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			mix = (n / 200) % 3;
			// Every field but the op starts random; the op then shapes the fields it uses.
			w = word_of(OP_REGISTER, 3'($urandom_range(0, 7)), $urandom(),
				24'($urandom_range(0, 24'hFF_FFFF)), 5'($urandom_range(0, 31)),
				16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
			r = (n < FILL_ITEMS) ? 0 : $urandom_range(0, 99);
			if (r < CUT_REG[mix]) begin
				w.op = OP_REGISTER;
				if ($urandom_range(0, 9) != 0) begin
					w.kind = 3'($urandom_range(KIND_CHARACTER, KIND_EXPLOSION));
				end else begin
					// Illegal kinds: none, or the three codes above explosion.
					w.kind = 3'($urandom_range(0, 3));
					if (w.kind != KIND_NONE)
						w.kind = w.kind + KIND_EXPLOSION;
				end
				w.entity_id = pick_owner();
				r = $urandom_range(0, 9);
				if (r < 3)
					w.lifetime = '0;
				else if (r < 8)
					w.lifetime = 24'($urandom_range(1, 2000));
			end else if (r < CUT_REM[mix] || (r >= CUT_TICK[mix] && r < CUT_LOOK[mix])) begin
				w.op = (r < CUT_REM[mix]) ? OP_REMOVE : OP_LOOKUP;
				// Mostly aim at a live slot with its current generation.
				for (tries = 0; tries < 4 && !shadow_active[w.handle_slot]; tries++)
					w.handle_slot = 5'($urandom_range(0, 31));
				if ($urandom_range(0, 4) != 0)
					w.handle_generation = shadow_gen[w.handle_slot];
			end else if (r < CUT_ENT[mix]) begin
				w.op = OP_REMOVE_ENT;
				if ($urandom_range(0, 6) != 0)
					w.entity_id = pick_owner();
			end else if (r < CUT_TICK[mix]) begin
				w.op = OP_TICK;
				r = $urandom_range(0, 9);
				if (r < 7)
					w.tick_delta = 16'($urandom_range(0, 400));
				else if (r < 9)
					w.tick_delta = 16'($urandom_range(401, 3000));
			end else begin
				w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			end

			// Words 600 to 799 go out with no random pauses between them.
			if (!(n >= 600 && n < 800) && $urandom_range(0, 99) < 36)
				pause($urandom_range(1, 40));
			send_word(w, 0, '0);
			if (n % 250 == 249)
				wait_for_answers();
		end

		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_answers.size() != 0) begin
			$error("%0d answer words never arrived", due_answers.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
